// ----- rtl/wto_pkg.sv -----
// Package for the wavetable oscillator.
// Holds table, phase and sample widths, command codes and register addresses.
// No dependencies.
package wto_pkg;

  localparam int TABLE_DEPTH   = 512;
  localparam int INDEX_BITS    = $clog2(TABLE_DEPTH);
  localparam int FRACTION_BITS = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int PHASE_BITS    = INDEX_BITS + FRACTION_BITS;
  localparam int STEP_BITS     = 25;
  localparam int RATE_BITS     = 16;
  localparam int RATE_SHIFT    = 12;
  localparam int SCALED_BITS   = STEP_BITS + RATE_BITS;
  localparam int DIFF_BITS     = SAMPLE_BITS + 1;
  localparam int PROD_BITS     = DIFF_BITS + FRACTION_BITS + 1;

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } command_t;

  localparam logic REG_PHASE_STEP = 1'b0;

  typedef logic        [INDEX_BITS-1:0]    index_t;
  typedef logic        [FRACTION_BITS-1:0] frac_t;
  typedef logic        [PHASE_BITS-1:0]    phase_t;
  typedef logic signed [SAMPLE_BITS-1:0]   sample_t;

endpackage

// ----- rtl/wto_interp.sv -----
// Interpolation datapath of the wavetable oscillator: difference times fraction,
// then offset add into the output register. Depends on wto_pkg.
module wto_interp (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  wto_pkg::sample_t lo_word,
  input  wto_pkg::sample_t hi_word,
  input  wto_pkg::frac_t   frac,
  output logic             out_valid,
  input  logic             out_ready,
  output wto_pkg::sample_t out_word
);
  import wto_pkg::*;

  logic                        prod_valid;
  logic signed [PROD_BITS-1:0] prod;
  sample_t                     base;
  logic                        out_free;
  logic                        prod_free;
  logic signed [DIFF_BITS-1:0] diff;
  logic signed [PROD_BITS-1:0] prod_next;

  assign out_free  = !out_valid || out_ready;
  assign prod_free = !prod_valid || out_free;
  assign in_ready  = prod_free;

  assign diff      = DIFF_BITS'(hi_word) - DIFF_BITS'(lo_word);
  assign prod_next = PROD_BITS'(diff) * $signed(PROD_BITS'({1'b0, frac}));

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (prod_free) begin
        prod_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_free) begin
      prod <= prod_next;
      base <= lo_word;
    end
    if (out_free) begin
      out_word <= base + prod[FRACTION_BITS +: SAMPLE_BITS];
    end
  end

endmodule

// ----- rtl/wavetable_oscillator.sv -----
// Top level of the wavetable oscillator: APB register, phase accumulator and
// the dual-read wave table. Depends on wto_pkg and wto_interp.
//
// Usage. Words enter on the item channel (item_valid/item_ready). A load word
// (command 0) writes entry_value into the table at entry_index and gives no
// sample. A tick word (command 1) gives one sample on the sample channel
// (sample_valid/sample_ready) and then advances the phase by
// (phase_step * rate_multiplier) >> 12, wrapping at the table length.
// phase_step is written over APB at address 0; pready is always high.
// Pipeline: a tick's two table reads and its fraction are registered, then the
// product and base, then the output word.
// Throughput: one word per cycle while sample_ready keeps the pipeline moving. The
// pending phase add feeds the table read of the two neighboring entries in the
// same cycle; the multiply for the next phase runs beside it.
// Stalls: while sample_ready is low the pipeline fills its two stages and the
// output register, then drops item_ready; no sample is lost.
// Reset clears phase, phase_step and all valid flags. Table contents are not
// cleared; the table must be loaded before ticks read it.
module wavetable_oscillator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wto_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [wto_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [wto_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic                                command,
  input  logic [wto_pkg::INDEX_BITS-1:0]      entry_index,
  input  logic signed [wto_pkg::SAMPLE_BITS-1:0] entry_value,
  input  logic [wto_pkg::RATE_BITS-1:0]       rate_multiplier,
  output logic                                sample_valid,
  input  logic                                sample_ready,
  output logic signed [wto_pkg::SAMPLE_BITS-1:0] sample
);
  import wto_pkg::*;

  logic [STEP_BITS-1:0]   phase_step;
  phase_t                 phase;
  phase_t                 phase_cur;
  phase_t                 inc;
  logic                   inc_pend;
  logic [SCALED_BITS-1:0] scaled;
  logic                   tick_accept;
  logic                   load_accept;
  logic                   cfg_write;
  index_t                 idx_lo;
  index_t                 idx_hi;

  sample_t                wave_table [TABLE_DEPTH];
  sample_t                rd_lo;
  sample_t                rd_hi;
  frac_t                  rd_frac;
  logic                   rd_valid;
  logic                   rd_ready;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_PHASE_STEP) ? APB_DATA_BITS'(phase_step) : '0;

  assign item_ready  = !rd_valid || rd_ready;
  assign tick_accept = item_valid && item_ready && (command == CMD_TICK);
  assign load_accept = item_valid && item_ready && (command == CMD_LOAD);

  assign scaled    = SCALED_BITS'(phase_step) * SCALED_BITS'(rate_multiplier);
  assign phase_cur = phase + (inc_pend ? inc : '0);
  assign idx_lo    = phase_cur[PHASE_BITS-1 -: INDEX_BITS];
  assign idx_hi    = idx_lo + INDEX_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      phase      <= '0;
      inc_pend   <= 1'b0;
      rd_valid   <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == REG_PHASE_STEP) begin
        phase_step <= pwdata[STEP_BITS-1:0];
      end
      phase    <= phase_cur;
      inc_pend <= tick_accept;
      if (item_ready) begin
        rd_valid <= tick_accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      inc <= scaled[RATE_SHIFT +: PHASE_BITS];
    end
    if (item_ready) begin
      rd_lo   <= wave_table[idx_lo];
      rd_hi   <= wave_table[idx_hi];
      rd_frac <= phase_cur[FRACTION_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_accept && int'(entry_index) < TABLE_DEPTH) begin
      wave_table[entry_index] <= entry_value;
    end
  end

  wto_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_ready  (rd_ready),
    .lo_word   (rd_lo),
    .hi_word   (rd_hi),
    .frac      (rd_frac),
    .out_valid (sample_valid),
    .out_ready (sample_ready),
    .out_word  (sample)
  );

endmodule

// ----- tb/wto_checker.sv -----
// Checker for the wavetable oscillator: snoops the APB port and both word channels,
// keeps its own copy of phase, phase_step and the wave table, and compares every sample.
// Depends on wto_pkg.
module wto_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [wto_pkg::APB_ADDR_BITS-1:0]      paddr,
  input  logic [wto_pkg::APB_DATA_BITS-1:0]      pwdata,
  input  logic [wto_pkg::APB_DATA_BITS-1:0]      prdata,
  input  logic                                   pready,
  input  logic                                   item_valid,
  input  logic                                   item_ready,
  input  logic                                   command,
  input  logic [wto_pkg::INDEX_BITS-1:0]         entry_index,
  input  logic signed [wto_pkg::SAMPLE_BITS-1:0] entry_value,
  input  logic [wto_pkg::RATE_BITS-1:0]          rate_multiplier,
  input  logic                                   sample_valid,
  input  logic                                   sample_ready,
  input  logic signed [wto_pkg::SAMPLE_BITS-1:0] sample,
  output int                                     mismatches,
  output int                                     outstanding,
  output int                                     loads_seen,
  output int                                     ticks_seen,
  output int                                     samples_seen
);
  import wto_pkg::*;

  logic [STEP_BITS-1:0] step_reg = '0;
  phase_t               phase_acc = '0;
  sample_t              wave_copy [TABLE_DEPTH];
  sample_t              expected_samples [$];
  int                   errors = 0;
  int                   loads = 0;
  int                   ticks = 0;
  int                   checked = 0;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    loads_seen   = 0;
    ticks_seen   = 0;
    samples_seen = 0;
  end

  // The shift of the signed product rounds toward minus infinity.
  function automatic sample_t interpolate_sample(phase_t ph);
    index_t lo_idx;
    index_t hi_idx;
    longint lo_val;
    longint hi_val;
    longint frac;
    lo_idx = ph[PHASE_BITS-1:FRACTION_BITS];
    hi_idx = (lo_idx == index_t'(TABLE_DEPTH - 1)) ? '0 : lo_idx + 1'b1;
    lo_val = wave_copy[lo_idx];
    hi_val = wave_copy[hi_idx];
    frac   = ph[FRACTION_BITS-1:0];
    return sample_t'(lo_val + (((hi_val - lo_val) * frac) >>> FRACTION_BITS));
  endfunction

  // The phase width spans exactly the table length, so truncation is the wrap.
  function automatic phase_t advance_phase(phase_t ph, logic [RATE_BITS-1:0] rate);
    logic [SCALED_BITS-1:0] scaled;
    scaled = SCALED_BITS'(step_reg) * SCALED_BITS'(rate);
    return ph + phase_t'(scaled >> RATE_SHIFT);
  endfunction

  always @(posedge clk) begin
    sample_t want;
    if (rst) begin
      step_reg  = '0;
      phase_acc = '0;
      expected_samples.delete();
    end else begin
      if (psel && penable && pready && paddr[APB_ADDR_BITS-1:2] == REG_PHASE_STEP) begin
        if (pwrite) begin
          step_reg = pwdata[STEP_BITS-1:0];
        end else if (prdata !== APB_DATA_BITS'(step_reg)) begin
          $display("%0t: phase_step read mismatch: expected %0h, got %0h",
                   $time, step_reg, prdata);
          errors++;
        end
      end
      if (sample_valid && sample_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: sample mismatch: expected none, got %0d", $time, sample);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          checked++;
          if (sample !== want) begin
            $display("%0t: sample mismatch: expected %0d, got %0d", $time, want, sample);
            errors++;
          end
        end
      end
      if (item_valid && item_ready) begin
        if (command == CMD_TICK) begin
          expected_samples.push_back(interpolate_sample(phase_acc));
          phase_acc = advance_phase(phase_acc, rate_multiplier);
          ticks++;
        end else begin
          wave_copy[entry_index] = entry_value;
          loads++;
        end
      end
    end
    mismatches   <= errors;
    outstanding  <= expected_samples.size();
    loads_seen   <= loads;
    ticks_seen   <= ticks;
    samples_seen <= checked;
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the wavetable oscillator testbench: clock, reset, APB accesses, word stimulus,
// receiver stalls, watchdog and verdict. Depends on wto_pkg, wto_checker and
// wavetable_oscillator.
module testbench;
  import wto_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  localparam logic [APB_ADDR_BITS-1:0] STEP_ADDR  = {REG_PHASE_STEP, 2'b00};
  localparam logic [APB_ADDR_BITS-1:0] SPARE_ADDR = {~REG_PHASE_STEP, 2'b00};
  localparam int STEP_MAX          = 2**STEP_BITS - 1;
  localparam int SEGMENTS          = 8;
  localparam int WORDS_PER_SEGMENT = 100;
  localparam int PRESSURE_SEGMENT  = 5;
  localparam int HOLD_CYCLES       = 300;
  localparam int DRAIN_CYCLES      = 8;
  localparam int WATCHDOG_LIMIT    = 3000;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     item_valid = 1'b0;
  logic                     item_ready;
  logic                     command = CMD_LOAD;
  index_t                   entry_index = '0;
  sample_t                  entry_value = '0;
  logic [RATE_BITS-1:0]     rate_multiplier = '0;
  logic                     sample_valid;
  logic                     sample_ready = 1'b0;
  sample_t                  sample;

  int mismatches;
  int outstanding;
  int loads_seen;
  int ticks_seen;
  int samples_seen;

  int   gap_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;
  int   settings = 0;

  wavetable_oscillator u_dut (.*);

  wto_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      sample_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      sample_ready <= 1'b0;
    end else begin
      sample_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (sample_valid && sample_ready) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic set_idling(idling_t mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct = 0;
        stall_pct <= 0;
      end
      IDLE_SENDER: begin
        gap_pct = 53;
        stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0;
        stall_pct <= 53;
      end
      default: begin
        gap_pct = 27;
        stall_pct <= 27;
      end
    endcase
  endtask

  task automatic apb_access(logic write, logic [APB_ADDR_BITS-1:0] addr,
                            logic [APB_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_word(command_t cmd, index_t idx, sample_t val,
                           logic [RATE_BITS-1:0] rate);
    while ($urandom_range(0, 99) < gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid      <= 1'b1;
    command         <= cmd;
    entry_index     <= idx;
    entry_value     <= val;
    rate_multiplier <= rate;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic send_random_word();
    int                   pick;
    logic [RATE_BITS-1:0] rate;
    sample_t              val;
    pick = $urandom_range(0, 99);
    if (pick < 20)
      rate = RATE_BITS'(1 << RATE_SHIFT);
    else if (pick < 25)
      rate = '0;
    else if (pick < 30)
      rate = '1;
    else
      rate = RATE_BITS'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5)
      val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    else if (pick < 10)
      val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    else
      val = sample_t'($urandom);
    send_word(($urandom_range(0, 99) < 70) ? CMD_TICK : CMD_LOAD,
              index_t'($urandom), val, rate);
  endtask

  // Loads give no sample, so after the last sample the task still idles through a
  // drain wait before the register is touched.
  task automatic quiesce();
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(logic [STEP_BITS-1:0] step);
    apb_access(1'b1, STEP_ADDR, APB_DATA_BITS'(step));
    apb_access(1'b0, STEP_ADDR, '0);
    settings++;
  endtask

  initial begin
    logic [STEP_BITS-1:0] step;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_idling(IDLE_NONE);

    // Half an entry past the last index, so the second tick straddles the wrap.
    write_step({index_t'(TABLE_DEPTH - 1), 1'b1, {(FRACTION_BITS-1){1'b0}}});
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_word(CMD_LOAD, index_t'(i), sample_t'($urandom), RATE_BITS'($urandom));

    send_word(CMD_LOAD, '0, {1'b1, {(SAMPLE_BITS-1){1'b0}}}, '1);
    send_word(CMD_LOAD, '1, {1'b0, {(SAMPLE_BITS-1){1'b1}}}, '0);
    send_word(CMD_LOAD, index_t'(1), {1'b0, {(SAMPLE_BITS-1){1'b1}}}, '0);
    send_word(CMD_TICK, '1, '1, RATE_BITS'(1 << RATE_SHIFT));
    send_word(CMD_TICK, '0, '0, '0);
    send_word(CMD_TICK, index_t'($urandom), sample_t'($urandom), '1);
    send_word(CMD_LOAD, '1, {1'b1, {(SAMPLE_BITS-1){1'b0}}}, '1);
    send_word(CMD_LOAD, '0, '0, RATE_BITS'($urandom));
    repeat (4)
      send_word(CMD_TICK, index_t'($urandom), sample_t'($urandom), RATE_BITS'(1 << RATE_SHIFT));
    send_word(CMD_TICK, index_t'($urandom), sample_t'($urandom), '1);
    send_word(CMD_TICK, index_t'($urandom), sample_t'($urandom), RATE_BITS'($urandom));

    quiesce();
    apb_access(1'b1, SPARE_ADDR, '1);
    apb_access(1'b0, STEP_ADDR, '0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      quiesce();
      case (seg)
        0:       step = '0;
        1:       step = STEP_BITS'(STEP_MAX);
        2:       step = {index_t'(1), frac_t'(0)};
        default: step = (seg % 2 != 0) ? STEP_BITS'($urandom_range(0, STEP_MAX))
                                       : STEP_BITS'($urandom_range(1, 1 << 18));
      endcase
      write_step(step);
      if (seg == PRESSURE_SEGMENT) begin
        set_idling(IDLE_NONE);
        hold_req <= ~hold_req;
      end else begin
        set_idling(idling_t'(seg % 4));
      end
      repeat (WORDS_PER_SEGMENT) send_random_word();
    end
    quiesce();

    $display("Run covered %0d words, %0d table loads and %0d ticks, under %0d phase_step values.",
             loads_seen + ticks_seen, loads_seen, ticks_seen, settings);
    $display("%0d samples were compared with the predicted interpolation.", samples_seen);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
